FILE: sv/fss_pkg.sv
// Shared types and action codes for the frequency selection sampler.
`default_nettype none

package fss_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  typedef struct packed {
    logic    valid;
    action_e action;
    logic    eoe;
    logic    rem_nz;
  } ctl_t;

endpackage

`default_nettype wire

FILE: sv/fss_front.sv
// Input stage: remaining-event counter and the input register.
`default_nettype none

module fss_front #(
  parameter int COUNT_BITS    = 48,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  input  wire logic                     in_valid_i,
  input  wire logic [1:0]               action_i,
  input  wire logic [COUNT_BITS-1:0]    run_total_i,
  input  wire logic [COUNT_BITS-1:0]    run_target_i,
  input  wire logic [FRACTION_BITS-1:0] random_fraction_i,
  input  wire logic                     end_of_entry_i,
  output fss_pkg::ctl_t                 ctl_o,
  output logic [COUNT_BITS-1:0]         rem_o,
  output logic [FRACTION_BITS-1:0]      frac_o,
  output logic [COUNT_BITS-1:0]         target_o
);

  logic [COUNT_BITS-1:0]    remaining_q, remaining_d;
  fss_pkg::ctl_t            ctl_q, ctl_d;
  fss_pkg::action_e         act;
  logic                     accept;
  logic [COUNT_BITS-1:0]    rem_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [COUNT_BITS-1:0]    target_q;

  assign act    = fss_pkg::action_e'(action_i);
  assign accept = in_valid_i && advance_i;

  always_comb begin
    remaining_d = remaining_q;
    if (accept) begin
      if (act == fss_pkg::ACT_START) begin
        remaining_d = run_total_i;
      end else if (act == fss_pkg::ACT_EVENT && remaining_q != '0) begin
        remaining_d = remaining_q - COUNT_BITS'(1);
      end
    end
    ctl_d.valid  = in_valid_i;
    ctl_d.action = act;
    ctl_d.eoe    = end_of_entry_i;
    ctl_d.rem_nz = remaining_q != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      ctl_q       <= '0;
    end else begin
      remaining_q <= remaining_d;
      if (advance_i) begin
        ctl_q <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q    <= remaining_q;
      frac_q   <= random_fraction_i;
      target_q <= run_target_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign rem_o    = rem_q;
  assign frac_o   = frac_q;
  assign target_o = target_q;

endmodule

`default_nettype wire

FILE: sv/fss_mul.sv
// Two-stage multiplier: split partial products, then the summed product's integer part.
`default_nettype none

module fss_mul #(
  parameter int COUNT_BITS    = 48,
  parameter int FRACTION_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  input  wire fss_pkg::ctl_t            ctl_i,
  input  wire logic [COUNT_BITS-1:0]    rem_i,
  input  wire logic [FRACTION_BITS-1:0] frac_i,
  input  wire logic [COUNT_BITS-1:0]    target_i,
  output fss_pkg::ctl_t                 ctl_o,
  output logic [COUNT_BITS-1:0]         prod_o,
  output logic [COUNT_BITS-1:0]         target_o
);

  localparam int LoBits = (COUNT_BITS + 1) / 2;
  localparam int HiBits = COUNT_BITS - LoBits;
  localparam int PBits  = COUNT_BITS + FRACTION_BITS;

  fss_pkg::ctl_t                ctl_b_q, ctl_c_q;
  logic [LoBits+FRACTION_BITS-1:0] pp_lo_q;
  logic [HiBits+FRACTION_BITS-1:0] pp_hi_q;
  logic [COUNT_BITS-1:0]        target_b_q, target_c_q;
  logic [COUNT_BITS-1:0]        prod_q;
  logic [PBits-1:0]             sum;

  assign sum = PBits'(pp_lo_q) + (PBits'(pp_hi_q) << LoBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (advance_i) begin
      ctl_b_q <= ctl_i;
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pp_lo_q    <= (LoBits+FRACTION_BITS)'(rem_i[LoBits-1:0]) *
                    (LoBits+FRACTION_BITS)'(frac_i);
      pp_hi_q    <= (HiBits+FRACTION_BITS)'(rem_i[COUNT_BITS-1:LoBits]) *
                    (HiBits+FRACTION_BITS)'(frac_i);
      target_b_q <= target_i;
      prod_q     <= sum[PBits-1:FRACTION_BITS];
      target_c_q <= target_b_q;
    end
  end

  assign ctl_o    = ctl_c_q;
  assign prod_o   = prod_q;
  assign target_o = target_c_q;

endmodule

`default_nettype wire

FILE: sv/fss_update.sv
// Keep decision, selection and entry counters, and the result register.
`default_nettype none

module fss_update #(
  parameter int COUNT_BITS = 48,
  parameter int ENTRY_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  advance_i,
  input  wire fss_pkg::ctl_t         ctl_i,
  input  wire logic [COUNT_BITS-1:0] prod_i,
  input  wire logic [COUNT_BITS-1:0] target_i,
  output logic                       out_valid_o,
  output logic [ENTRY_BITS-1:0]      entry_count_o,
  output logic                       run_complete_o
);

  logic [COUNT_BITS-1:0] needed_q, needed_d;
  logic [ENTRY_BITS-1:0] kept_q, kept_d, count_d;
  logic [ENTRY_BITS-1:0] count_q;
  logic                  out_valid_q, emit, keep, complete_q;

  assign keep = ctl_i.rem_nz && (prod_i < needed_q);

  always_comb begin
    needed_d = needed_q;
    kept_d   = kept_q;
    emit     = 1'b0;
    if (ctl_i.valid) begin
      unique case (ctl_i.action)
        fss_pkg::ACT_START: begin
          needed_d = target_i;
          kept_d   = '0;
        end
        fss_pkg::ACT_EVENT: begin
          if (keep) begin
            needed_d = needed_q - COUNT_BITS'(1);
            if (kept_q != '1) begin
              kept_d = kept_q + ENTRY_BITS'(1);
            end
          end
          emit = ctl_i.eoe;
        end
        fss_pkg::ACT_CLOSE: emit = 1'b1;
        default: ;
      endcase
    end
    count_d = kept_d;
    if (emit) begin
      kept_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needed_q    <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      needed_q    <= needed_d;
      kept_q      <= kept_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && emit) begin
      count_q    <= count_d;
      complete_q <= needed_d == '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_count_o  = count_q;
  assign run_complete_o = complete_q;

endmodule

`default_nettype wire

FILE: sv/frequency_selection_sampler.sv
// Top level of the frequency selection sampler (selection sampling, Algorithm S).
//
//   channel | signals                         | direction
//   in      | in_valid_i / in_ready_o, fields | host -> block
//   out     | out_valid_o / out_ready_i       | block -> host
//
// One transaction per cycle while the output is not stalled.
// The chain is: input register, partial products, product sum, keep/update.
// A stall on the output freezes all stages together; in_ready_o follows it.
// Reset clears the counters: needed is zero, so a result emitted before any start reports run_complete as 1.
`default_nettype none

module frequency_selection_sampler #(
  parameter int COUNT_BITS    = 48,
  parameter int FRACTION_BITS = 32,
  parameter int ENTRY_BITS    = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               action_i,
  input  wire logic [COUNT_BITS-1:0]    run_total_i,
  input  wire logic [COUNT_BITS-1:0]    run_target_i,
  input  wire logic [FRACTION_BITS-1:0] random_fraction_i,
  input  wire logic                     end_of_entry_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ENTRY_BITS-1:0]         entry_count_o,
  output logic                          run_complete_o
);

  logic                     advance;
  fss_pkg::ctl_t            ctl_a, ctl_c;
  logic [COUNT_BITS-1:0]    rem_a, target_a, target_c, prod_c;
  logic [FRACTION_BITS-1:0] frac_a;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  fss_front #(
    .COUNT_BITS   (COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .in_valid_i       (in_valid_i),
    .action_i         (action_i),
    .run_total_i      (run_total_i),
    .run_target_i     (run_target_i),
    .random_fraction_i(random_fraction_i),
    .end_of_entry_i   (end_of_entry_i),
    .ctl_o            (ctl_a),
    .rem_o            (rem_a),
    .frac_o           (frac_a),
    .target_o         (target_a)
  );

  fss_mul #(
    .COUNT_BITS   (COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .ctl_i    (ctl_a),
    .rem_i    (rem_a),
    .frac_i   (frac_a),
    .target_i (target_a),
    .ctl_o    (ctl_c),
    .prod_o   (prod_c),
    .target_o (target_c)
  );

  fss_update #(
    .COUNT_BITS(COUNT_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_update (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .ctl_i         (ctl_c),
    .prod_i        (prod_c),
    .target_i      (target_c),
    .out_valid_o   (out_valid_o),
    .entry_count_o (entry_count_o),
    .run_complete_o(run_complete_o)
  );

endmodule

`default_nettype wire

FILE: sv/fss_checker.sv
// Port-level assertions for the frequency selection sampler, with its bind.
`default_nettype none

module fss_checker #(
  parameter int ENTRY_BITS = 32
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [ENTRY_BITS-1:0] entry_count_o,
  input wire logic                  run_complete_o
);

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(entry_count_o) && $stable(run_complete_o)))
    else $error("stalled result changed");

  a_no_result_without_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared during a stall");

endmodule

bind frequency_selection_sampler fss_checker #(
  .ENTRY_BITS(ENTRY_BITS)
) u_fss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .entry_count_o (entry_count_o),
  .run_complete_o(run_complete_o)
);

`default_nettype wire
